[design/dgcc_pkg.sv]
// ----------------------------------------------------------------------------
// dgcc_pkg: shared types and constants of the directed graph cycle checker
// Sizes, opcodes, stream widths, row and list types and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dgcc_pkg;

    localparam int VERTICES = 16;
    localparam int ID_SPAN  = 16;
    localparam int LIMIT    = (VERTICES < ID_SPAN) ? VERTICES : ID_SPAN;
    localparam int VW       = $clog2(VERTICES);
    localparam int LW       = $clog2(LIMIT);

    localparam int OPW          = 3;
    localparam int IDW          = 4;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [OPW-1:0] OP_ADD_VTX   = 3'd0;
    localparam logic [OPW-1:0] OP_ADD_EDGE  = 3'd1;
    localparam logic [OPW-1:0] OP_TEST_EDGE = 3'd2;
    localparam logic [OPW-1:0] OP_LIST_SUCC = 3'd3;
    localparam logic [OPW-1:0] OP_LIST_PRED = 3'd4;
    localparam logic [OPW-1:0] OP_ACYCLIC   = 3'd5;

    typedef logic [VW-1:0]       t_vid;
    typedef logic [VERTICES-1:0] t_row;
    typedef logic [LIMIT-1:0]    t_list;
    typedef logic [LW-1:0]       t_lidx;

    typedef struct packed {
        logic wr_vtx;
        logic wr_edge;
        logic rem_load;
        logic rem_upd;
        t_vid sel;
        t_vid col;
    } t_cell_ctl;

endpackage

[design/directed_graph_cycle_check.sv]
// ----------------------------------------------------------------------------
// directed_graph_cycle_check: directed graph store with acyclicity check
// A row of vertex cells keeps the graph; a small sequencer serves requests.
//
//   channel  dir  signals                         contents
//   s_axis   in   tvalid tready tdata[15:0]       opcode, vertex_a, vertex_b
//   m_axis   out  tvalid tready tdata[7:0] tlast  answer, neighbor; tlast=last
//
// Add vertex, add edge, test edge: one request per cycle while the output is free, result registered.
// Listing: scans ids in order up to the last neighbor (at most LIMIT ids).
// Acyclic check: rounds in which the accumulator runs down the cell row and the
// remaining set is updated, at most max(present-count, 1) rounds, then an emit step.
// Synchronous active-low reset clears the graph. Output stalls hold intake, listing and emit.
// ----------------------------------------------------------------------------
module directed_graph_cycle_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [2:0] opcode, [6:3] vertex_a, [10:7] vertex_b, [15:11] zero
    input  logic [dgcc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] answer, [4:1] neighbor, [7:5] zero
    output logic [dgcc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);
    import dgcc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LIST = 3'd1;
    localparam logic [2:0] ST_PASS = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]     r_state, n_state;
    t_list          r_list, n_list;
    t_lidx          r_idx, n_idx;
    t_vid           r_cnt, n_cnt;
    logic           r_ans, n_ans;
    logic           r_out_valid, n_out_valid;
    logic           r_out_ans, n_out_ans;
    logic [IDW-1:0] r_out_nb, n_out_nb;
    logic           r_out_last, n_out_last;

    logic [OPW-1:0] w_op;
    logic [IDW-1:0] w_a, w_b;
    logic           w_a_ok, w_b_ok;
    t_vid           w_a_idx, w_b_idx;
    logic           w_accept, w_slot_free;
    t_cell_ctl      w_ctl;
    t_row           w_row [VERTICES];
    t_row           w_acc [VERTICES];
    t_row           w_acc_in [VERTICES];
    t_row           w_present, w_rem, w_new_rem;
    t_list          w_hits, w_onehot;

    assign w_op    = i_s_axis_tdata[2:0];
    assign w_a     = i_s_axis_tdata[6:3];
    assign w_b     = i_s_axis_tdata[10:7];
    assign w_a_ok  = int'(w_a) < VERTICES;
    assign w_b_ok  = int'(w_b) < VERTICES;
    assign w_a_idx = VW'(w_a);
    assign w_b_idx = VW'(w_b);

    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < VERTICES; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_acc_in[g] = '0;
            end else begin : g_link
                assign w_acc_in[g] = w_acc[g-1];
            end
            dgcc_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_id      (VW'(g)),
                .i_ctl     (w_ctl),
                .i_keep    (w_acc[VERTICES-1][g]),
                .i_acc     (w_acc_in[g]),
                .o_acc     (w_acc[g]),
                .o_row     (w_row[g]),
                .o_present (w_present[g]),
                .o_rem     (w_rem[g])
            );
        end
    endgenerate

    always_comb begin
        for (int v = 0; v < LIMIT; v++) begin
            if (w_op == OP_LIST_SUCC) begin
                w_hits[v] = w_a_ok && w_row[w_a_idx][v];
            end else begin
                w_hits[v] = w_a_ok && w_present[v] && w_row[v][w_a_idx];
            end
        end
    end

    assign w_onehot  = LIMIT'(1) << r_idx;
    assign w_new_rem = w_rem & w_acc[VERTICES-1];

    always_comb begin
        n_state     = r_state;
        n_list      = r_list;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_ans       = r_ans;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_ans   = r_out_ans;
        n_out_nb    = r_out_nb;
        n_out_last  = r_out_last;
        w_ctl       = '{wr_vtx: 1'b0, wr_edge: 1'b0, rem_load: 1'b0, rem_upd: 1'b0,
                        sel: w_a_idx, col: w_b_idx};

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_out_nb    = '0;
                    n_out_last  = 1'b1;
                    n_out_ans   = 1'b0;
                    unique case (w_op) inside
                        OP_ADD_VTX: begin
                            w_ctl.wr_vtx = w_a_ok;
                            n_out_ans    = w_a_ok;
                        end
                        OP_ADD_EDGE: begin
                            w_ctl.wr_edge = w_a_ok && w_b_ok;
                            n_out_ans     = w_a_ok && w_b_ok;
                        end
                        OP_TEST_EDGE: begin
                            n_out_ans = w_a_ok && w_b_ok && w_row[w_a_idx][w_b_idx];
                        end
                        OP_LIST_SUCC, OP_LIST_PRED: begin
                            if (w_hits != '0) begin
                                n_out_valid = 1'b0;
                                n_list      = w_hits;
                                n_idx       = '0;
                                n_state     = ST_LIST;
                            end
                        end
                        OP_ACYCLIC: begin
                            n_out_valid    = 1'b0;
                            w_ctl.rem_load = 1'b1;
                            n_cnt          = '0;
                            n_state        = ST_PASS;
                        end
                        default: begin
                            n_out_ans = 1'b0;
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (!r_list[r_idx]) begin
                    n_idx = r_idx + 1'b1;
                end else if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_ans   = 1'b1;
                    n_out_nb    = IDW'(r_idx);
                    n_out_last  = (r_list == w_onehot);
                    n_list      = r_list & ~w_onehot;
                    n_idx       = r_idx + 1'b1;
                    if (r_list == w_onehot) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PASS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == VW'(VERTICES - 1)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                w_ctl.rem_upd = 1'b1;
                n_cnt         = '0;
                if ((w_new_rem == w_rem) || (w_new_rem == '0)) begin
                    n_ans   = (w_new_rem == '0);
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PASS;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_ans   = r_ans;
                    n_out_nb    = '0;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_list     <= n_list;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_ans      <= n_ans;
        r_out_ans  <= n_out_ans;
        r_out_nb   <= n_out_nb;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - IDW - 1)'(0), r_out_nb, r_out_ans};
    assign o_m_axis_tlast  = r_out_last;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_axis_tready)
        else $error("request accepted while sequencer busy");

    a_update_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> ($past(r_state) == ST_PASS))
        else $error("remaining-set update without a full pass");

    a_nonzero_neighbor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[4:1] != '0)) |-> o_m_axis_tdata[0])
        else $error("neighbor reported on an invalid entry");

    a_single_result_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((w_op == OP_ADD_VTX) || (w_op == OP_ADD_EDGE) ||
                      (w_op == OP_TEST_EDGE)))
        |=> (o_m_axis_tvalid && o_m_axis_tlast && (r_state == ST_IDLE)))
        else $error("single-result request did not produce its result");

endmodule

[design/dgcc_cell.sv]
// ----------------------------------------------------------------------------
// dgcc_cell: one vertex of the graph
// Holds the vertex's present bit and outgoing adjacency row, plus its
// remaining bit for the peeling check, and forwards the in-edge accumulator.
// ----------------------------------------------------------------------------
module dgcc_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dgcc_pkg::t_vid       i_id,
    input  dgcc_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_keep,
    input  dgcc_pkg::t_row       i_acc,
    output dgcc_pkg::t_row       o_acc,
    output dgcc_pkg::t_row       o_row,
    output logic                 o_present,
    output logic                 o_rem
);
    import dgcc_pkg::*;

    t_row r_row;
    logic r_present;
    logic r_rem;
    t_row r_acc;
    logic w_hit;

    assign w_hit = (i_ctl.sel == i_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_present <= 1'b0;
        end else begin
            if (i_ctl.wr_vtx && w_hit) begin
                r_present <= 1'b1;
            end
            if (i_ctl.wr_edge && w_hit) begin
                r_row[i_ctl.col] <= 1'b1;
            end
        end
    end

    // in-edge accumulator moves one cell per cycle
    always_ff @(posedge i_clk) begin
        r_acc <= i_acc | (r_rem ? r_row : '0);
        if (i_ctl.rem_load) begin
            r_rem <= r_present;
        end else if (i_ctl.rem_upd) begin
            r_rem <= r_rem & i_keep;
        end
    end

    assign o_acc     = r_acc;
    assign o_row     = r_row;
    assign o_present = r_present;
    assign o_rem     = r_rem;

endmodule
